// File: rtl/lfrg_pkg.sv
package lfrg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TIME_BITS = 24;

	localparam int LVL_W = FRAC_BITS + 1;
	localparam int RATE_W = 16;
	localparam int DT_W = 16;
	localparam int RND_W = 16;
	localparam int INT_W = 16;
	localparam int PHASE_W = 2;

	// shift-add multiplier: wide operand a, 16-bit operand b consumed one bit a cycle
	localparam int MUL_B_W = 16;
	localparam int MUL_A_W = (TIME_BITS > LVL_W) ? TIME_BITS : LVL_W;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

	// ramp step = (rate * dt) << FRAC_BITS >> 24
	localparam int STEP_SHIFT = 24 - FRAC_BITS;
	localparam int STEP_W = RATE_W + DT_W - STEP_SHIFT;
	localparam int LVL_SUM_W = STEP_W + 1;

	localparam logic [LVL_W-1:0] ONE_LEVEL = LVL_W'(1) << FRAC_BITS;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;
	localparam int TDATA_IN_W = 32;
	localparam int TDATA_OUT_W = 24;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_RATE = 3'd1;
	localparam logic [2:0] REG_MIN_DEPTH = 3'd2;
	localparam logic [2:0] REG_MAX_DEPTH = 3'd3;
	localparam logic [2:0] REG_MIN_WAIT = 3'd4;
	localparam logic [2:0] REG_MAX_WAIT = 3'd5;
	localparam logic [2:0] REG_BASE = 3'd6;

	localparam logic [PHASE_W-1:0] PH_WAIT = 2'd0;
	localparam logic [PHASE_W-1:0] PH_DIM = 2'd1;
	localparam logic [PHASE_W-1:0] PH_BRIGHT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_STEP_MUL,
		ST_INT_MUL,
		ST_WDRAW_MUL,
		ST_WAIT_UPD,
		ST_DDRAW_MUL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_STEP,
		MUL_INT,
		MUL_WAIT,
		MUL_DEPTH
	} mul_sel_t;

endpackage

// File: rtl/light_flicker_ramp_generator_unit.sv
// light flicker ramp generator
// input stream: one beat per time tick, s_tdata = {random_fraction, delta_time}.
// output stream: one beat per input beat, m_tdata = {phase, intensity}, m_tuser marks
// a tick that set a new ramp intensity.
// configuration registers sit on the apb port at byte address 4*index; the user must
// make writes only while no tick is in flight; the block does not enforce it. a
// disabled tick goes from decide to done; a waiting tick makes any pending wait draw,
// updates the elapsed time and draws a depth when the wait ends; a ramp tick computes
// the step and scales the intensity, and the tick that ends brightening also draws
// the next wait. the result beat becomes valid in the same cycle that the next tick
// can be taken. every product goes through one shift-add multiplier that takes one
// bit of its 16-bit operand per cycle, and the draws, the ramp step and the intensity
// scaling take turns on it. one tick is worked on at a time; s_tready is high only
// between ticks. a finished beat waits in the output register while the next tick is
// taken, and a stalled receiver holds the block before the next result is written.
// reset clears the flicker machine to waiting with a wait draw pending and loads the
// register defaults; the block is disabled after reset.
module light_flicker_ramp_generator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [lfrg_pkg::TDATA_IN_W-1:0] s_tdata,   // delta_time, random_fraction
	output logic m_tvalid,
	input  logic m_tready,
	output logic [lfrg_pkg::TDATA_OUT_W-1:0] m_tdata,  // intensity, phase, zero pad
	output logic m_tuser,                                // intensity_valid
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [lfrg_pkg::CFG_AW-1:0] paddr,
	input  logic [lfrg_pkg::CFG_DW-1:0] pwdata,
	output logic [lfrg_pkg::CFG_DW-1:0] prdata,
	output logic pready
);

	lfrg_pkg::state_t state_q, state_nx;

	// configuration
	logic enable_q;
	logic [lfrg_pkg::RATE_W-1:0] rate_q;
	logic [lfrg_pkg::LVL_W-1:0] min_depth_q, max_depth_q;
	logic [lfrg_pkg::TIME_BITS-1:0] min_wait_q, max_wait_q;
	logic [lfrg_pkg::INT_W-1:0] base_q;

	// flicker state
	logic [lfrg_pkg::PHASE_W-1:0] phase_q;
	logic [lfrg_pkg::TIME_BITS-1:0] elapsed_q, wait_target_q;
	logic [lfrg_pkg::LVL_W-1:0] level_q, depth_q;
	logic draw_pending_q;
	logic ramp_end_q;

	// tick and result
	logic [lfrg_pkg::DT_W-1:0] dt_q;
	logic [lfrg_pkg::RND_W-1:0] rnd_q;
	logic [lfrg_pkg::INT_W-1:0] res_int_q;
	logic res_flag_q;
	logic m_tvalid_q;
	logic [lfrg_pkg::INT_W-1:0] m_int_q;
	logic [lfrg_pkg::PHASE_W-1:0] m_phase_q;
	logic m_flag_q;

	// multiplier
	logic [lfrg_pkg::MUL_A_W-1:0] mul_a_q, mul_a_in;
	logic [lfrg_pkg::MUL_A_W-1:0] mul_hi_q;
	logic [lfrg_pkg::MUL_B_W-1:0] mul_lo_q, mul_b_in;
	logic [lfrg_pkg::MUL_CNT_W-1:0] mul_cnt_q;
	logic [lfrg_pkg::MUL_A_W:0] mul_sum;
	logic [lfrg_pkg::PROD_W-1:0] prod;
	logic mul_done;
	logic mul_start;
	lfrg_pkg::mul_sel_t mul_sel;
	logic res_load;

	logic cfg_wr;
	logic [2:0] cfg_idx;
	logic ramping;

	// draws
	logic wait_ge, depth_ge;
	logic [lfrg_pkg::TIME_BITS-1:0] wait_diff, wait_draw;
	logic [lfrg_pkg::LVL_W-1:0] depth_diff, depth_draw, depth_sat;

	// level update
	logic [lfrg_pkg::STEP_W-1:0] step;
	logic [lfrg_pkg::LVL_SUM_W-1:0] lvl_ext, step_ext, lvl_raw, lvl_clamp;
	logic [lfrg_pkg::LVL_W-1:0] level_next;

	// wait update
	logic [lfrg_pkg::TIME_BITS:0] elapsed_sum;
	logic [lfrg_pkg::TIME_BITS-1:0] elapsed_next;
	logic wait_hit;

	assign cfg_wr = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];
	assign pready = 1'b1;

	always_comb begin
		case (cfg_idx)
			lfrg_pkg::REG_ENABLE: prdata = lfrg_pkg::CFG_DW'(enable_q);
			lfrg_pkg::REG_RATE: prdata = lfrg_pkg::CFG_DW'(rate_q);
			lfrg_pkg::REG_MIN_DEPTH: prdata = lfrg_pkg::CFG_DW'(min_depth_q);
			lfrg_pkg::REG_MAX_DEPTH: prdata = lfrg_pkg::CFG_DW'(max_depth_q);
			lfrg_pkg::REG_MIN_WAIT: prdata = lfrg_pkg::CFG_DW'(min_wait_q);
			lfrg_pkg::REG_MAX_WAIT: prdata = lfrg_pkg::CFG_DW'(max_wait_q);
			lfrg_pkg::REG_BASE: prdata = lfrg_pkg::CFG_DW'(base_q);
			default: prdata = '0;
		endcase
	end

	assign s_tready = (state_q == lfrg_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(lfrg_pkg::TDATA_OUT_W - lfrg_pkg::INT_W - lfrg_pkg::PHASE_W){1'b0}},
		m_phase_q, m_int_q};
	assign m_tuser = m_flag_q;

	assign ramping = (phase_q == lfrg_pkg::PH_DIM) || (phase_q == lfrg_pkg::PH_BRIGHT);

	// multiplier datapath
	assign mul_done = (mul_cnt_q == '0);
	assign mul_sum = {1'b0, mul_hi_q} + (mul_lo_q[0] ? {1'b0, mul_a_q} : '0);
	assign prod = {mul_hi_q, mul_lo_q};

	// draws: lo + ((hi - lo) * r >> 16), toward lo when bounds are reversed
	assign wait_ge = (max_wait_q >= min_wait_q);
	assign wait_diff = wait_ge ? (max_wait_q - min_wait_q) : (min_wait_q - max_wait_q);
	assign wait_draw = wait_ge ? (min_wait_q + mul_hi_q[lfrg_pkg::TIME_BITS-1:0])
		: (min_wait_q - mul_hi_q[lfrg_pkg::TIME_BITS-1:0]);
	assign depth_ge = (max_depth_q >= min_depth_q);
	assign depth_diff = depth_ge ? (max_depth_q - min_depth_q) : (min_depth_q - max_depth_q);
	assign depth_draw = depth_ge ? (min_depth_q + mul_hi_q[lfrg_pkg::LVL_W-1:0])
		: (min_depth_q - mul_hi_q[lfrg_pkg::LVL_W-1:0]);
	assign depth_sat = (depth_draw > lfrg_pkg::ONE_LEVEL) ? lfrg_pkg::ONE_LEVEL : depth_draw;

	// level ramp with clamp to [depth, one]
	assign step = prod[lfrg_pkg::STEP_SHIFT +: lfrg_pkg::STEP_W];
	assign lvl_ext = lfrg_pkg::LVL_SUM_W'(level_q);
	assign step_ext = lfrg_pkg::LVL_SUM_W'(step);

	always_comb begin
		if (phase_q == lfrg_pkg::PH_DIM) begin
			lvl_raw = (lvl_ext > step_ext) ? (lvl_ext - step_ext) : '0;
		end else begin
			lvl_raw = lvl_ext + step_ext;
		end
		lvl_clamp = lvl_raw;
		if (lvl_clamp < lfrg_pkg::LVL_SUM_W'(depth_q)) begin
			lvl_clamp = lfrg_pkg::LVL_SUM_W'(depth_q);
		end
		if (lvl_clamp > lfrg_pkg::LVL_SUM_W'(lfrg_pkg::ONE_LEVEL)) begin
			lvl_clamp = lfrg_pkg::LVL_SUM_W'(lfrg_pkg::ONE_LEVEL);
		end
		level_next = lvl_clamp[lfrg_pkg::LVL_W-1:0];
	end

	assign elapsed_sum = {1'b0, elapsed_q} + (lfrg_pkg::TIME_BITS + 1)'(dt_q);
	assign elapsed_next = elapsed_sum[lfrg_pkg::TIME_BITS] ? lfrg_pkg::TIME_MAX
		: elapsed_sum[lfrg_pkg::TIME_BITS-1:0];
	assign wait_hit = (elapsed_next >= wait_target_q);

	always_comb begin
		case (mul_sel)
			lfrg_pkg::MUL_STEP: begin
				mul_a_in = lfrg_pkg::MUL_A_W'(rate_q);
				mul_b_in = dt_q;
			end
			lfrg_pkg::MUL_INT: begin
				mul_a_in = lfrg_pkg::MUL_A_W'(level_next);
				mul_b_in = base_q;
			end
			lfrg_pkg::MUL_WAIT: begin
				mul_a_in = lfrg_pkg::MUL_A_W'(wait_diff);
				mul_b_in = rnd_q;
			end
			default: begin
				mul_a_in = lfrg_pkg::MUL_A_W'(depth_diff);
				mul_b_in = rnd_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			lfrg_pkg::ST_IDLE: if (s_tvalid) state_nx = lfrg_pkg::ST_DECIDE;
			lfrg_pkg::ST_DECIDE: begin
				if (!enable_q) state_nx = lfrg_pkg::ST_DONE;
				else if (ramping) state_nx = lfrg_pkg::ST_STEP_MUL;
				else if (draw_pending_q) state_nx = lfrg_pkg::ST_WDRAW_MUL;
				else state_nx = lfrg_pkg::ST_WAIT_UPD;
			end
			lfrg_pkg::ST_STEP_MUL: if (mul_done) state_nx = lfrg_pkg::ST_INT_MUL;
			lfrg_pkg::ST_INT_MUL: begin
				if (mul_done) begin
					state_nx = ramp_end_q ? lfrg_pkg::ST_WDRAW_MUL : lfrg_pkg::ST_DONE;
				end
			end
			lfrg_pkg::ST_WDRAW_MUL: begin
				if (mul_done) begin
					state_nx = ramp_end_q ? lfrg_pkg::ST_DONE : lfrg_pkg::ST_WAIT_UPD;
				end
			end
			lfrg_pkg::ST_WAIT_UPD: begin
				state_nx = wait_hit ? lfrg_pkg::ST_DDRAW_MUL : lfrg_pkg::ST_DONE;
			end
			lfrg_pkg::ST_DDRAW_MUL: if (mul_done) state_nx = lfrg_pkg::ST_DONE;
			lfrg_pkg::ST_DONE: if (res_load) state_nx = lfrg_pkg::ST_IDLE;
			default: state_nx = lfrg_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		mul_start = 1'b0;
		mul_sel = lfrg_pkg::MUL_STEP;
		res_load = 1'b0;
		case (state_q)
			lfrg_pkg::ST_DECIDE: begin
				if (enable_q && ramping) begin
					mul_start = 1'b1;
					mul_sel = lfrg_pkg::MUL_STEP;
				end else if (enable_q && draw_pending_q) begin
					mul_start = 1'b1;
					mul_sel = lfrg_pkg::MUL_WAIT;
				end
			end
			lfrg_pkg::ST_STEP_MUL: begin
				mul_start = mul_done;
				mul_sel = lfrg_pkg::MUL_INT;
			end
			lfrg_pkg::ST_INT_MUL: begin
				mul_start = mul_done && ramp_end_q;
				mul_sel = lfrg_pkg::MUL_WAIT;
			end
			lfrg_pkg::ST_WAIT_UPD: begin
				mul_start = wait_hit;
				mul_sel = lfrg_pkg::MUL_DEPTH;
			end
			lfrg_pkg::ST_DONE: res_load = !m_tvalid_q || m_tready;
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfrg_pkg::ST_IDLE;
			mul_a_q <= '0;
			mul_hi_q <= '0;
			mul_lo_q <= '0;
			mul_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (mul_start) begin
				mul_a_q <= mul_a_in;
				mul_hi_q <= '0;
				mul_lo_q <= mul_b_in;
				mul_cnt_q <= lfrg_pkg::MUL_CNT_W'(lfrg_pkg::MUL_B_W);
			end else if (!mul_done) begin
				mul_hi_q <= mul_sum[lfrg_pkg::MUL_A_W:1];
				mul_lo_q <= {mul_sum[0], mul_lo_q[lfrg_pkg::MUL_B_W-1:1]};
				mul_cnt_q <= mul_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			rate_q <= lfrg_pkg::RATE_W'(2048);
			min_depth_q <= '0;
			max_depth_q <= lfrg_pkg::LVL_W'(52429);
			min_wait_q <= lfrg_pkg::TIME_BITS'(19661);
			max_wait_q <= lfrg_pkg::TIME_BITS'(32768);
			base_q <= '0;
			phase_q <= lfrg_pkg::PH_WAIT;
			elapsed_q <= '0;
			wait_target_q <= '0;
			level_q <= '0;
			depth_q <= '0;
			draw_pending_q <= 1'b1;
			ramp_end_q <= 1'b0;
			dt_q <= '0;
			rnd_q <= '0;
			res_int_q <= '0;
			res_flag_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_int_q <= '0;
			m_phase_q <= '0;
			m_flag_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					lfrg_pkg::REG_ENABLE: begin
						enable_q <= pwdata[0];
						// enabling restarts the wait with a fresh draw
						if (pwdata[0]) begin
							phase_q <= lfrg_pkg::PH_WAIT;
							elapsed_q <= '0;
							draw_pending_q <= 1'b1;
						end
					end
					lfrg_pkg::REG_RATE: rate_q <= pwdata[lfrg_pkg::RATE_W-1:0];
					lfrg_pkg::REG_MIN_DEPTH: min_depth_q <= pwdata[lfrg_pkg::LVL_W-1:0];
					lfrg_pkg::REG_MAX_DEPTH: max_depth_q <= pwdata[lfrg_pkg::LVL_W-1:0];
					lfrg_pkg::REG_MIN_WAIT: min_wait_q <= pwdata[lfrg_pkg::TIME_BITS-1:0];
					lfrg_pkg::REG_MAX_WAIT: max_wait_q <= pwdata[lfrg_pkg::TIME_BITS-1:0];
					lfrg_pkg::REG_BASE: base_q <= pwdata[lfrg_pkg::INT_W-1:0];
					default: begin
						enable_q <= enable_q;
					end
				endcase
			end

			if (s_tvalid && s_tready) begin
				dt_q <= s_tdata[lfrg_pkg::DT_W-1:0];
				rnd_q <= s_tdata[lfrg_pkg::DT_W +: lfrg_pkg::RND_W];
			end

			case (state_q)
				lfrg_pkg::ST_DECIDE: begin
					res_int_q <= base_q;
					res_flag_q <= 1'b0;
					ramp_end_q <= 1'b0;
					if (enable_q && !ramping) phase_q <= lfrg_pkg::PH_WAIT;
				end
				lfrg_pkg::ST_STEP_MUL: begin
					if (mul_done) begin
						level_q <= level_next;
						if (phase_q == lfrg_pkg::PH_DIM) begin
							if (level_next <= depth_q) phase_q <= lfrg_pkg::PH_BRIGHT;
						end else if (level_next >= lfrg_pkg::ONE_LEVEL) begin
							phase_q <= lfrg_pkg::PH_WAIT;
							elapsed_q <= '0;
							ramp_end_q <= 1'b1;
						end
					end
				end
				lfrg_pkg::ST_INT_MUL: begin
					if (mul_done) begin
						res_int_q <= prod[lfrg_pkg::FRAC_BITS +: lfrg_pkg::INT_W];
						res_flag_q <= 1'b1;
					end
				end
				lfrg_pkg::ST_WDRAW_MUL: begin
					if (mul_done) begin
						wait_target_q <= wait_draw;
						draw_pending_q <= 1'b0;
					end
				end
				lfrg_pkg::ST_WAIT_UPD: begin
					elapsed_q <= elapsed_next;
					if (wait_hit) phase_q <= lfrg_pkg::PH_DIM;
				end
				lfrg_pkg::ST_DDRAW_MUL: begin
					if (mul_done) depth_q <= depth_sat;
				end
				default: begin
					ramp_end_q <= ramp_end_q;
				end
			endcase

			if (res_load) begin
				m_tvalid_q <= 1'b1;
				m_int_q <= res_int_q;
				m_phase_q <= phase_q;
				m_flag_q <= res_flag_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= lfrg_pkg::ONE_LEVEL)
		else $error("level above one");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= lfrg_pkg::ONE_LEVEL)
		else $error("depth target above one");

	a_mul_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!mul_done && state_q != lfrg_pkg::ST_IDLE) |=> (state_q == $past(state_q)))
		else $error("state left while multiplier busy");

	a_draw_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lfrg_pkg::ST_WDRAW_MUL && mul_done && !cfg_wr) |=> !draw_pending_q)
		else $error("wait draw left pending");
`endif

endmodule

// File: dv/testbench.sv
module testbench;

	typedef struct packed {
		logic [lfrg_pkg::DT_W-1:0]  delta_time;
		logic [lfrg_pkg::RND_W-1:0] rnd;
	} tick_in_t;

	typedef struct packed {
		logic [lfrg_pkg::INT_W-1:0]   intensity;
		logic                         ramp_valid;
		logic [lfrg_pkg::PHASE_W-1:0] phase;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [lfrg_pkg::TDATA_IN_W-1:0] s_tdata = '0;   // delta_time, random_fraction
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [lfrg_pkg::TDATA_OUT_W-1:0] m_tdata;       // intensity, phase, zero pad
	logic m_tuser;                                   // intensity_valid
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [lfrg_pkg::CFG_AW-1:0] paddr = '0;
	logic [lfrg_pkg::CFG_DW-1:0] pwdata = '0;
	logic [lfrg_pkg::CFG_DW-1:0] prdata;
	logic pready;

	light_flicker_ramp_generator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// flicker predictor: settings and machine state
	logic [63:0] cfg_enable, cfg_rate, cfg_min_depth, cfg_max_depth;
	logic [63:0] cfg_min_wait, cfg_max_wait, cfg_base;
	logic [63:0] prd_phase, prd_elapsed, prd_wait_target, prd_level, prd_depth_target;
	logic        prd_draw_pending;

	tick_in_t     tick_queue[$];
	tick_result_t expected_ticks[$];
	tick_in_t     next_tick;
	int           ticks_sent = 0;
	int           results_seen = 0;
	int           mismatches = 0;

	function automatic logic [63:0] scaled_draw(input logic [63:0] lo, input logic [63:0] hi,
			input logic [63:0] r);
		if (hi >= lo)
			return lo + (((hi - lo) * r) >> 16);
		return lo - (((lo - hi) * r) >> 16);
	endfunction

	function automatic void apply_setting(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			lfrg_pkg::REG_ENABLE: begin
				cfg_enable = 64'(val[0]);
				if (val[0]) begin
					prd_phase = 64'(lfrg_pkg::PH_WAIT);
					prd_elapsed = 0;
					prd_draw_pending = 1'b1;
				end
			end
			lfrg_pkg::REG_RATE: cfg_rate = 64'(val[lfrg_pkg::RATE_W-1:0]);
			lfrg_pkg::REG_MIN_DEPTH: cfg_min_depth = 64'(val[lfrg_pkg::LVL_W-1:0]);
			lfrg_pkg::REG_MAX_DEPTH: cfg_max_depth = 64'(val[lfrg_pkg::LVL_W-1:0]);
			lfrg_pkg::REG_MIN_WAIT: cfg_min_wait = 64'(val[lfrg_pkg::TIME_BITS-1:0]);
			lfrg_pkg::REG_MAX_WAIT: cfg_max_wait = 64'(val[lfrg_pkg::TIME_BITS-1:0]);
			lfrg_pkg::REG_BASE: cfg_base = 64'(val[lfrg_pkg::INT_W-1:0]);
			default: ;
		endcase
	endfunction

	function automatic tick_result_t flicker_tick(input logic [lfrg_pkg::DT_W-1:0] dt,
			input logic [lfrg_pkg::RND_W-1:0] rnd);
		tick_result_t res;
		logic [63:0] step;
		logic [63:0] one;
		one = 64'(lfrg_pkg::ONE_LEVEL);
		res.intensity = cfg_base[lfrg_pkg::INT_W-1:0];
		res.ramp_valid = 1'b0;
		if (cfg_enable[0]) begin
			step = ((cfg_rate * 64'(dt)) << lfrg_pkg::FRAC_BITS) >> 24;
			if (prd_phase == 64'(lfrg_pkg::PH_DIM) || prd_phase == 64'(lfrg_pkg::PH_BRIGHT))
					begin
				if (prd_phase == 64'(lfrg_pkg::PH_DIM))
					prd_level = (prd_level > step) ? prd_level - step : 64'd0;
				else
					prd_level = prd_level + step;
				if (prd_level < prd_depth_target)
					prd_level = prd_depth_target;
				if (prd_level > one)
					prd_level = one;
				res.intensity = lfrg_pkg::INT_W'((prd_level * cfg_base) >> lfrg_pkg::FRAC_BITS);
				res.ramp_valid = 1'b1;
				if (prd_phase == 64'(lfrg_pkg::PH_DIM)) begin
					if (prd_level <= prd_depth_target)
						prd_phase = 64'(lfrg_pkg::PH_BRIGHT);
				end else if (prd_level >= one) begin
					// end of brightening draws the next wait
					prd_phase = 64'(lfrg_pkg::PH_WAIT);
					prd_elapsed = 0;
					prd_wait_target = scaled_draw(cfg_min_wait, cfg_max_wait, 64'(rnd))
						& 64'(lfrg_pkg::TIME_MAX);
					prd_draw_pending = 1'b0;
				end
			end else begin
				prd_phase = 64'(lfrg_pkg::PH_WAIT);
				if (prd_draw_pending) begin
					prd_wait_target = scaled_draw(cfg_min_wait, cfg_max_wait, 64'(rnd))
						& 64'(lfrg_pkg::TIME_MAX);
					prd_draw_pending = 1'b0;
				end
				prd_elapsed = prd_elapsed + 64'(dt);
				if (prd_elapsed > 64'(lfrg_pkg::TIME_MAX))
					prd_elapsed = 64'(lfrg_pkg::TIME_MAX);
				if (prd_elapsed >= prd_wait_target) begin
					prd_phase = 64'(lfrg_pkg::PH_DIM);
					prd_depth_target = scaled_draw(cfg_min_depth, cfg_max_depth, 64'(rnd));
					if (prd_depth_target > one)
						prd_depth_target = one;
				end
			end
		end
		res.phase = prd_phase[lfrg_pkg::PHASE_W-1:0];
		return res;
	endfunction

	function automatic logic [31:0] rand_setting(input logic [31:0] hi);
		int unsigned sel;
		sel = $urandom_range(5);
		if (sel == 0)
			return 32'd0;
		if (sel == 1)
			return hi;
		return $urandom_range(hi);
	endfunction

	// tick source: one beat per tick, idles at random outside the calm stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_ticks.push_back(flicker_tick(s_tdata[15:0], s_tdata[31:16]));
				ticks_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (tick_queue.size() != 0 &&
						((ticks_sent >= 300 && ticks_sent < 450) || $urandom_range(99) >= 16)) begin
					next_tick = tick_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {next_tick.rnd, next_tick.delta_time};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_ticks.size() == 0) begin
					$error("result beat with no tick pending: intensity %0d", m_tdata[15:0]);
					mismatches++;
				end else begin
					tick_result_t want;
					want = expected_ticks.pop_front();
					if (m_tdata[15:0] !== want.intensity) begin
						$error("intensity: expected %0d, actual %0d", want.intensity, m_tdata[15:0]);
						mismatches++;
					end
					if (m_tuser !== want.ramp_valid) begin
						$error("intensity_valid: expected %0d, actual %0d", want.ramp_valid, m_tuser);
						mismatches++;
					end
					if (m_tdata[17:16] !== want.phase) begin
						$error("phase: expected %0d, actual %0d", want.phase, m_tdata[17:16]);
						mismatches++;
					end
				end
			end
			m_tready <= (results_seen >= 300 && results_seen < 450) || $urandom_range(99) >= 16;
		end
	end

	task automatic write_setting(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_setting(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_tick(input logic [15:0] dt, input logic [15:0] rnd);
		tick_in_t t;
		t.delta_time = dt;
		t.rnd = rnd;
		tick_queue.push_back(t);
	endtask

	// settle at the falling edge so the source and sink have finished their beats
	task automatic wait_idle();
		do @(negedge clk);
		while (tick_queue.size() != 0 || s_tvalid || expected_ticks.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_waits_depths(input logic [31:0] dmin, input logic [31:0] dmax,
			input logic [31:0] wmin, input logic [31:0] wmax);
		write_setting(lfrg_pkg::REG_MIN_DEPTH, dmin);
		write_setting(lfrg_pkg::REG_MAX_DEPTH, dmax);
		write_setting(lfrg_pkg::REG_MIN_WAIT, wmin);
		write_setting(lfrg_pkg::REG_MAX_WAIT, wmax);
	endtask

	initial begin
		int unsigned dt_max;
		int unsigned wait_ceil;
		int unsigned n_ticks;

		cfg_enable = 0;
		cfg_rate = 2048;
		cfg_min_depth = 0;
		cfg_max_depth = 52429;
		cfg_min_wait = 19661;
		cfg_max_wait = 32768;
		cfg_base = 0;
		prd_phase = 64'(lfrg_pkg::PH_WAIT);
		prd_elapsed = 0;
		prd_wait_target = 0;
		prd_level = 0;
		prd_depth_target = 0;
		prd_draw_pending = 1'b1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// disabled after reset, default settings
		queue_tick(16'h0000, 16'h0000);
		queue_tick(16'hffff, 16'hffff);
		wait_idle();

		// zero wait, full rate: first dim lands on the target at once
		write_setting(lfrg_pkg::REG_RATE, 32'hffff);
		write_setting(lfrg_pkg::REG_BASE, 32'hffff);
		write_waits_depths(32'd0, 32'd65536, 32'd0, 32'd0);
		write_setting(lfrg_pkg::REG_ENABLE, 32'd1);
		queue_tick(16'h0000, 16'h0000);
		queue_tick(16'hffff, 16'hffff);
		queue_tick(16'h0001, 16'h0000);
		queue_tick(16'hffff, 16'hffff);
		queue_tick(16'h0005, 16'hffff);
		queue_tick(16'h0064, 16'h0000);
		queue_tick(16'h0000, 16'h8000);
		queue_tick(16'h0001, 16'h1234);
		wait_idle();

		// reversed bounds; wait draw and depth draw share one tick
		write_waits_depths(32'd65536, 32'd0, 32'hffffff, 32'd0);
		write_setting(lfrg_pkg::REG_ENABLE, 32'd1);
		queue_tick(16'hffff, 16'hffff);
		queue_tick(16'h0008, 16'h0000);
		wait_idle();

		// depth beyond one saturates
		write_waits_depths(32'h1ffff, 32'h1ffff, 32'd0, 32'd0);
		write_setting(lfrg_pkg::REG_ENABLE, 32'd1);
		queue_tick(16'h0000, 16'h5555);
		queue_tick(16'h000a, 16'haaaa);
		queue_tick(16'h000a, 16'h0f0f);
		queue_tick(16'h0000, 16'hf0f0);
		queue_tick(16'h0003, 16'h0000);
		wait_idle();

		// disabled in mid-flicker keeps state
		write_setting(lfrg_pkg::REG_ENABLE, 32'd0);
		queue_tick(16'h0003, 16'h0003);
		queue_tick(16'h7fff, 16'h8001);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: dt_max = 4000;
				3: dt_max = 65535;
				default: dt_max = ($urandom_range(2) == 0) ? 255 :
					(($urandom_range(1) == 0) ? 4095 : 65535);
			endcase
			wait_ceil = (dt_max * 16 > 32'hffffff) ? 32'hffffff : dt_max * 16;
			n_ticks = (ph == 3) ? 300 : (ph == 6) ? 30 : (ph == 7) ? 70 : 130;

			if (ph == 0) begin
				write_setting(lfrg_pkg::REG_RATE, 32'd2048);
				write_waits_depths(32'd0, 32'd52429, 32'd19661, 32'd32768);
			end else if (ph == 3) begin
				// waits long enough for the elapsed counter to saturate
				write_setting(lfrg_pkg::REG_RATE, 32'hffff);
				write_waits_depths(rand_setting(65536), rand_setting(65536),
					32'hffffff, 32'hffffff);
			end else begin
				write_setting(lfrg_pkg::REG_RATE, rand_setting(32'hffff));
				write_waits_depths(rand_setting(65536), rand_setting(65536),
					rand_setting(wait_ceil), rand_setting(wait_ceil));
			end
			write_setting(lfrg_pkg::REG_BASE, rand_setting(32'hffff));
			// phase five keeps the running machine across the new settings
			if (ph == 6)
				write_setting(lfrg_pkg::REG_ENABLE, 32'd0);
			else if (ph != 5)
				write_setting(lfrg_pkg::REG_ENABLE, 32'd1);

			for (int i = 0; i < n_ticks; i++) begin
				if (ph == 3)
					queue_tick(16'($urandom_range(65535, 60000)), 16'($urandom_range(65535)));
				else
					queue_tick(16'($urandom_range(dt_max)), 16'($urandom_range(65535)));
			end
			wait_idle();
		end

		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("[light_flicker_ramp_generator_unit] OK");
		else
			$display("[light_flicker_ramp_generator_unit] ERROR");
		$finish;
	end

	initial begin
		#10000000;
		$display("[light_flicker_ramp_generator_unit] ERROR");
		$finish;
	end

endmodule
